@@ rtl/itst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itst_pkg: shared types and constants of the session tracker
// Holds the table entry layout, the controller command and status groups,
// the stream field widths and the register map.
// ----------------------------------------------------------------------------
package itst_pkg;

    localparam int KEY_W        = 32;
    localparam int TS_W         = 32;
    localparam int HOUR_W       = 5;
    localparam int CNT32_W      = 32;
    localparam int TIMEOUT_W    = 17;
    localparam int IN_TDATA_W   = 72;
    localparam int OUT_TDATA_W  = 136;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 17'd1800;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_IDLE_TIMEOUT = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TS_W-1:0]    start;
        logic [TS_W-1:0]    last_seen;
        logic [CNT32_W-1:0] hits;
    } itst_entry_t;

    typedef struct packed {
        logic latch;
        logic rd;
        logic commit;
    } itst_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } itst_sts_t;

endpackage : itst_pkg
`default_nettype wire

@@ rtl/itst_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itst_ctrl: sequencer of the session tracker
// Takes one transaction, walks the used table entries, then commits the
// update and hands the result to the output register.
// ----------------------------------------------------------------------------
module itst_ctrl
    import itst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire itst_sts_t sts,
    output itst_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.rd = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : itst_ctrl
`default_nettype wire

@@ rtl/itst_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itst_datapath: host table, hour totals and result register
// The host table is a memory filled from entry zero upward; the fill count
// marks which entries are in use. One entry is read per scan cycle.
// ----------------------------------------------------------------------------
module itst_datapath
    import itst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int HOUR_BUCKETS  = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire itst_cmd_t              cmd,
    output itst_sts_t                   sts,
    input  wire logic [IN_TDATA_W-1:0]  in_data,
    input  wire logic                   in_kind,
    input  wire logic [TIMEOUT_W-1:0]   idle_timeout,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OUT_TDATA_W-1:0]      out_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int HB_W  = (HOUR_BUCKETS > 1) ? $clog2(HOUR_BUCKETS) : 1;
    localparam int HX_W  = 7;

    itst_entry_t entry_mem [TABLE_ENTRIES];

    logic                 kind_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TS_W-1:0]      ts_reg;
    logic [HOUR_W-1:0]    hour_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic                 rvld_reg;
    itst_entry_t          rdata_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    itst_entry_t          hit_entry_reg;
    logic                 hit_idle_reg;
    logic [CNT32_W-1:0]   acc_reg;
    logic [CNT32_W-1:0]   hour_cnt_reg  [HOUR_BUCKETS];
    logic [CNT32_W-1:0]   hour_time_reg [HOUR_BUCKETS];
    logic                 out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                 rd_match;
    logic                 rd_idle;
    logic [HX_W-1:0]      hour_ext;
    logic                 hour_ok;
    logic [HB_W-1:0]      hidx;
    logic                 is_access;
    logic                 full;
    logic                 new_host;
    logic                 closed;
    logic                 tbl_full;
    logic [CNT32_W-1:0]   hit_len;
    logic [CNT32_W-1:0]   closed_len;
    logic [CNT32_W-1:0]   hits_inc;
    logic [CNT32_W-1:0]   host_hits;
    logic [CNT32_W-1:0]   add_cnt;
    logic [CNT32_W-1:0]   add_time;
    logic [CNT32_W-1:0]   cnt_next;
    logic [CNT32_W-1:0]   time_next;
    logic [CNT32_W-1:0]   out_cnt;
    logic [CNT32_W-1:0]   out_time;
    itst_entry_t          wr_entry;

    assign rd_match = rvld_reg && (kind_reg == KIND_ACCESS) && !found_reg
                      && (rdata_reg.key == key_reg);
    assign rd_idle  = ({2'b00, rdata_reg.last_seen} + {17'd0, idle_timeout})
                      < {2'b00, ts_reg};

    assign hour_ext  = {2'b00, hour_reg};
    assign hour_ok   = hour_ext < HX_W'(HOUR_BUCKETS);
    assign hidx      = hour_ext[HB_W-1:0];
    assign is_access = (kind_reg == KIND_ACCESS);
    assign full      = (fill_reg == CNT_W'(TABLE_ENTRIES));
    assign new_host  = is_access && !found_reg && !full;
    assign tbl_full  = is_access && !found_reg && full;
    assign closed    = is_access && found_reg && hit_idle_reg;
    assign hit_len   = hit_entry_reg.last_seen - hit_entry_reg.start;
    assign closed_len = closed ? hit_len : '0;
    assign hits_inc  = hit_entry_reg.hits + 32'd1;

    always_comb
    begin
        host_hits = '0;
        if (is_access && found_reg)
        begin
            host_hits = hits_inc;
        end
        else if (new_host)
        begin
            host_hits = 32'd1;
        end
    end

    assign add_cnt  = is_access ? {31'd0, closed} : 32'(fill_reg);
    assign add_time = is_access ? closed_len : acc_reg;
    assign cnt_next  = (hour_ok ? hour_cnt_reg[hidx] : '0) + add_cnt;
    assign time_next = (hour_ok ? hour_time_reg[hidx] : '0) + add_time;
    assign out_cnt  = hour_ok ? cnt_next : '0;
    assign out_time = hour_ok ? time_next : '0;

    always_comb
    begin
        wr_entry.key       = key_reg;
        wr_entry.start     = ts_reg;
        wr_entry.last_seen = ts_reg;
        wr_entry.hits      = 32'd1;
        if (found_reg)
        begin
            wr_entry.start = hit_idle_reg ? ts_reg : hit_entry_reg.start;
            wr_entry.hits  = hits_inc;
        end
    end

    assign sts.scan_end = (scan_reg == fill_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= entry_mem[scan_reg[IDX_W-1:0]];
        end
        if (cmd.commit && is_access && found_reg)
        begin
            entry_mem[hit_idx_reg] <= wr_entry;
        end
        else if (cmd.commit && new_host)
        begin
            entry_mem[fill_reg[IDX_W-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= in_kind;
            key_reg  <= in_data[31:0];
            ts_reg   <= in_data[63:32];
            hour_reg <= in_data[68:64];
        end
        if (rd_match)
        begin
            hit_idx_reg   <= scan_reg[IDX_W-1:0] - IDX_W'(1);
            hit_entry_reg <= rdata_reg;
            hit_idle_reg  <= rd_idle;
        end
        if (cmd.commit)
        begin
            out_data_reg <= {5'd0, out_time, out_cnt, tbl_full, host_hits,
                             closed_len, closed, new_host};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            scan_reg      <= '0;
            rvld_reg      <= 1'b0;
            found_reg     <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < HOUR_BUCKETS; b++)
            begin
                hour_cnt_reg[b]  <= '0;
                hour_time_reg[b] <= '0;
            end
        end
        else
        begin
            rvld_reg <= cmd.rd;
            if (cmd.latch)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                acc_reg   <= '0;
            end
            else
            begin
                if (cmd.rd)
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                if (rd_match)
                begin
                    found_reg <= 1'b1;
                end
                if (rvld_reg && (kind_reg == KIND_CLOSE))
                begin
                    acc_reg <= acc_reg + (rdata_reg.last_seen - rdata_reg.start);
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (new_host)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
                if (hour_ok)
                begin
                    hour_cnt_reg[hidx]  <= cnt_next;
                    hour_time_reg[hidx] <= time_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : itst_datapath
`default_nettype wire

@@ rtl/idle_timeout_session_tracker_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idle_timeout_session_tracker_unit: per-host session tracker
// Tracks host sessions ended by idle time and keeps per-hour totals.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions arrive on the s_axis group. tuser selects the kind:
// zero is a host access, one is a close-hour walk. Every input transaction
// yields exactly one result transaction on the m_axis group.
// Each transaction reads the used host entries one per cycle from the
// single-port table memory, then commits and loads the result into the
// output register once that register is free. Only one transaction is
// worked on at a time. The idle timeout register is written over the APB
// port; the user must write it only while the block is idle, as the block
// itself does not enforce this.
// Reset empties the host table, clears all hour totals and sets the idle
// timeout to 1800 seconds. A stalled receiver holds the result in the
// output register; the next transaction is still accepted and scanned, and
// it waits for the output register before it commits.
// ----------------------------------------------------------------------------
module idle_timeout_session_tracker_unit
    import itst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int HOUR_BUCKETS  = 24
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // host_key[31:0], time_stamp[63:32], hour[68:64], zero fill above.
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // kind.
    input  wire logic                    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // new_host[0], session_closed[1], closed_length[33:2], host_hits[65:34],
    // table_full[66], hour_sessions[98:67], hour_time[130:99], zero fill above.
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    logic [TIMEOUT_W-1:0] idle_timeout_reg;
    itst_cmd_t            cmd;
    itst_sts_t            sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_IDLE_TIMEOUT))
        begin
            idle_timeout_reg <= pwdata[TIMEOUT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDLE_TIMEOUT) ? 32'(idle_timeout_reg) : '0;

    itst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HOUR_BUCKETS  (HOUR_BUCKETS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_data      (s_axis_tdata),
        .in_kind      (s_axis_tuser),
        .idle_timeout (idle_timeout_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

endmodule : idle_timeout_session_tracker_unit
`default_nettype wire

@@ rtl/itst_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// itst_checker: port-level checks of the session tracker
// Watches the stream ports and flags handshakes and results that cannot occur.
// ----------------------------------------------------------------------------
module itst_checker
    import itst_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken during a scan");

    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[66]))
        else $error("new host and table full together");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[33:2] == 32'd0)
        else $error("closed length without a closed session");

endmodule : itst_checker

bind idle_timeout_session_tracker_unit itst_checker u_itst_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
